>>> rtl/kemp_pkg.sv
// ----------------------------------------------------------------------------
// kemp_pkg
// shared types, byte codes, status codes and gain constants for the key
// event message parser
// ----------------------------------------------------------------------------
package kemp_pkg;

  // framing and message type bytes
  localparam logic [7:0] START_BYTE = 8'h53;
  localparam logic [7:0] END_BYTE   = 8'h0A;
  localparam logic [7:0] KIND_DOWN  = 8'h44;
  localparam logic [7:0] KIND_UP    = 8'h55;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] WS_LO      = 8'h09;
  localparam logic [7:0] WS_HI      = 8'h0D;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TOO_LONG = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE = 3'd2;
  localparam logic [2:0] ST_BAD_KEY  = 3'd3;
  localparam logic [2:0] ST_BAD_TIME = 3'd4;

  // number parser flags
  localparam logic [1:0] PF_SKIP    = 2'd0;
  localparam logic [1:0] PF_DIGITS  = 2'd1;
  localparam logic [1:0] PF_STOPPED = 2'd2;
  localparam logic [1:0] PF_FAILED  = 2'd3;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  // gain: n = 103*(10000-t) held to [100000, 1000000]
  // amplitude = floor((n*1024 + 46875) / 93750), done as a reciprocal multiply
  localparam logic [31:0] GAIN_T_LO   = 32'd291;
  localparam logic [31:0] GAIN_T_HI   = 32'd9030;
  localparam logic [13:0] GAIN_T_REF  = 14'd10000;
  localparam logic [19:0] GAIN_SLOPE  = 20'd103;
  localparam logic [19:0] GAIN_N_MAX  = 20'd1000000;
  localparam logic [19:0] GAIN_N_MIN  = 20'd100000;
  localparam logic [29:0] GAIN_BIAS   = 30'd46875;
  localparam logic [30:0] GAIN_RECIP  = 31'd1501199876;
  localparam int          GAIN_SHIFT  = 47;

  typedef struct packed {
    logic [1:0]  flags;
    logic [31:0] acc;
  } parse_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        key_down;
    logic [6:0]  key_number;
    logic [31:0] onset_time;
  } result_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= DIGIT_ZERO) && (b <= DIGIT_NINE);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == SPACE_CHAR) || ((b >= WS_LO) && (b <= WS_HI));
  endfunction

  // one decimal parser step, saturating at 32 bits
  function automatic parse_t parse_step(input logic [1:0] flags, input logic [31:0] acc,
                                        input logic [7:0] b);
    parse_t      r;
    logic [35:0] v;
    r.flags = flags;
    r.acc   = acc;
    v = 36'(acc) * 36'd10 + 36'(b - DIGIT_ZERO);
    if ((flags == PF_SKIP) || (flags == PF_DIGITS)) begin
      if (is_digit(b)) begin
        r.flags = PF_DIGITS;
        r.acc   = (v > 36'(TIME_MAX)) ? TIME_MAX : v[31:0];
      end else if (flags == PF_SKIP) begin
        r.flags = is_space(b) ? PF_SKIP : PF_FAILED;
      end else begin
        r.flags = PF_STOPPED;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/key_event_message_parser_core.sv
// ----------------------------------------------------------------------------
// key_event_message_parser_core
// parses framed key down / key up messages from a serial byte stream and
// emits one result word with status, key, voice slot, attack time and gain
// ----------------------------------------------------------------------------
// throughput: one byte word per cycle while the output word is not held
// a result is presented once its terminating LF has been taken and it has
//   passed stage 1 (the decoded message), stage 2 (the gain/slot products)
//   and the output register
// the whole pipeline stalls together while an output word waits
// reset: synchronous active-low rst_n clears parser state and all valid bits
module key_event_message_parser_core #(
  parameter int MAX_LEN    = 20,
  parameter int NUM_VOICES = 35
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_key_down,
  output logic [6:0]  out_key_number,
  output logic [5:0]  out_voice_slot,
  output logic [31:0] out_onset_time,
  output logic [13:0] out_amplitude
);
  import kemp_pkg::*;

  // byte counter width: must hold MAX_LEN itself
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  // voice slot: q = (key * VS_RECIP) >> VS_SHIFT is exact for 7-bit keys
  localparam int VS_SHIFT = 14;
  localparam int VS_RECIP = ((1 << VS_SHIFT) + NUM_VOICES - 1) / NUM_VOICES;
  localparam logic [7:0]  VS_DIV  = 8'(NUM_VOICES);
  localparam logic [14:0] VS_MULT = 15'(VS_RECIP);

  // ---------------------------------------------------------------------------
  // parser state
  // ---------------------------------------------------------------------------
  logic             in_msg_r, in_msg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       kind_r, kind_nxt;
  logic [6:0]       key_acc_r, key_acc_nxt;
  logic [1:0]       key_flags_r, key_flags_nxt;
  logic [31:0]      time_acc_r, time_acc_nxt;
  logic [1:0]       time_flags_r, time_flags_nxt;
  logic [7:0]       held_r, held_nxt;

  // pipeline
  logic      s1_valid_r, s1_valid_nxt;
  result_t   s1_res_r, s1_res_nxt;
  logic [19:0] s1_n_r, s1_n_nxt;
  logic      s2_valid_r;
  result_t   s2_res_r;
  logic [13:0] s2_amp_r;
  logic [6:0]  s2_quot_r;
  logic      out_valid_r;
  result_t   out_res_r;
  logic [13:0] out_amp_r;
  logic [5:0]  out_slot_r;

  logic       en;
  logic       accept;
  parse_t     key_step, time_step;
  logic [7:0] b;

  // the pipeline moves as a whole unless the output word is held
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && en;
  assign b        = in_rx_byte;

  // key parser sees the incoming byte; time parser lags one byte behind so
  // that the trailing CR never reaches it
  assign key_step  = parse_step(key_flags_r, 32'(key_acc_r), b);
  assign time_step = parse_step(time_flags_r, time_acc_r, held_r);

  // ---------------------------------------------------------------------------
  // per-byte parser update and end of message decode
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [7:0] kind_eff;
    logic [1:0] kflags_eff;
    logic       key_pos;
    logic [2:0] st;
    logic [13:0] m;

    in_msg_nxt     = in_msg_r;
    cnt_nxt        = cnt_r;
    kind_nxt       = kind_r;
    key_acc_nxt    = key_acc_r;
    key_flags_nxt  = key_flags_r;
    time_acc_nxt   = time_acc_r;
    time_flags_nxt = time_flags_r;
    held_nxt       = held_r;
    s1_valid_nxt   = 1'b0;
    s1_res_nxt     = '0;
    s1_n_nxt       = '0;
    kind_eff       = kind_r;
    kflags_eff     = key_flags_r;
    st             = ST_OK;
    m              = '0;

    key_pos = (cnt_r == CNT_W'(2)) || (cnt_r == CNT_W'(3));

    if (!in_msg_r) begin
      // hunting for the start byte
      if (b == START_BYTE) begin
        in_msg_nxt     = 1'b1;
        cnt_nxt        = '0;
        kind_nxt       = '0;
        key_acc_nxt    = '0;
        key_flags_nxt  = PF_SKIP;
        time_acc_nxt   = '0;
        time_flags_nxt = PF_SKIP;
        held_nxt       = '0;
      end
    end else if (b != END_BYTE) begin
      // message body; bytes past MAX_LEN are dropped but still tracked
      if (cnt_r < CNT_W'(MAX_LEN)) begin
        if (cnt_r == '0) kind_nxt = b;
        if (key_pos) begin
          key_acc_nxt   = key_step.acc[6:0];
          key_flags_nxt = key_step.flags;
        end
        if (cnt_r >= CNT_W'(5)) begin
          time_acc_nxt   = time_step.acc;
          time_flags_nxt = time_step.flags;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      held_nxt = b;
    end else begin
      // terminating LF: decode and launch a result
      in_msg_nxt   = 1'b0;
      held_nxt     = b;
      s1_valid_nxt = 1'b1;
      if (cnt_r == '0) kind_eff = b;
      if (key_pos) kflags_eff = key_step.flags;

      priority if (({1'b0, cnt_r} + (CNT_W+1)'(1)) >= (CNT_W+1)'(MAX_LEN)) begin
        st = ST_TOO_LONG;
      end else if ((kind_eff != KIND_DOWN) && (kind_eff != KIND_UP)) begin
        st = ST_BAD_TYPE;
      end else if ((kflags_eff != PF_DIGITS) && (kflags_eff != PF_STOPPED)) begin
        st = ST_BAD_KEY;
      end else if ((kind_eff == KIND_DOWN) && (time_flags_r != PF_DIGITS) &&
                   (time_flags_r != PF_STOPPED)) begin
        st = ST_BAD_TIME;
      end else begin
        st = ST_OK;
      end

      s1_res_nxt.status = st;
      if (st == ST_OK) begin
        s1_res_nxt.key_down   = (kind_eff == KIND_DOWN);
        s1_res_nxt.key_number = key_acc_r;
        if (kind_eff == KIND_DOWN) s1_res_nxt.onset_time = time_acc_r;
      end

      // clamped gain numerator n = 103*(10000-t)
      m = GAIN_T_REF - time_acc_r[13:0];
      priority if (time_acc_r <= GAIN_T_LO) begin
        s1_n_nxt = GAIN_N_MAX;
      end else if (time_acc_r >= GAIN_T_HI) begin
        s1_n_nxt = GAIN_N_MIN;
      end else begin
        s1_n_nxt = 20'(m) * GAIN_SLOPE;
      end
    end
  end

  // stage 2 products
  logic [29:0] gain_num;
  logic [60:0] gain_prod;
  logic [21:0] slot_prod;
  logic [13:0] slot_back;

  assign gain_num  = {s1_n_r, 10'b0} + GAIN_BIAS;
  assign gain_prod = 61'(gain_num) * 61'(GAIN_RECIP);
  assign slot_prod = 22'(s1_res_r.key_number) * 22'(VS_MULT);
  // output stage: remainder from the registered quotient
  assign slot_back = 14'(s2_quot_r) * 14'(VS_DIV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r     <= 1'b0;
      cnt_r        <= '0;
      kind_r       <= '0;
      key_acc_r    <= '0;
      key_flags_r  <= PF_SKIP;
      time_acc_r   <= '0;
      time_flags_r <= PF_SKIP;
      held_r       <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (en) begin
      if (accept) begin
        in_msg_r     <= in_msg_nxt;
        cnt_r        <= cnt_nxt;
        kind_r       <= kind_nxt;
        key_acc_r    <= key_acc_nxt;
        key_flags_r  <= key_flags_nxt;
        time_acc_r   <= time_acc_nxt;
        time_flags_r <= time_flags_nxt;
        held_r       <= held_nxt;
      end
      s1_valid_r  <= accept && s1_valid_nxt;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      s1_res_r  <= s1_res_nxt;
      s1_n_r    <= s1_n_nxt;
      s2_res_r  <= s1_res_r;
      s2_amp_r  <= gain_prod[GAIN_SHIFT+13:GAIN_SHIFT];
      s2_quot_r <= slot_prod[VS_SHIFT+6:VS_SHIFT];
      out_res_r <= s2_res_r;
      out_slot_r <= 6'(14'(s2_res_r.key_number) - slot_back);
      // gain only for a good key down message
      out_amp_r <= ((s2_res_r.status == ST_OK) && s2_res_r.key_down) ? s2_amp_r : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_key_down    = out_res_r.key_down;
  assign out_key_number  = out_res_r.key_number;
  assign out_voice_slot  = out_slot_r;
  assign out_onset_time  = out_res_r.onset_time;
  assign out_amplitude   = out_amp_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_key_number == '0) && (out_voice_slot == '0) &&
      (out_onset_time == '0) && (out_amplitude == '0) && !out_key_down)
    else $error("error word carries nonzero fields");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) && out_key_down |->
      (out_amplitude >= 14'd1092) && (out_amplitude <= 14'd10923))
    else $error("amplitude out of range");

  a_up_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_key_down |-> (out_onset_time == '0) && (out_amplitude == '0))
    else $error("key up word with time or gain");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_voice_slot) < 32'(NUM_VOICES)))
    else $error("voice slot beyond voice count");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(MAX_LEN))
    else $error("byte counter past limit");

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for key_event_message_parser_core: a byte stream of
// framed key down / key up messages, malformed frames and line noise is
// driven in, a parser model built into the bench predicts each result word,
// and a monitor compares every field in order
// ----------------------------------------------------------------------------
module testbench;
  import kemp_pkg::*;

  // block configuration, passed to the instance as well
  localparam int MSG_MAX_LEN = 20;
  localparam int VOICE_COUNT = 35;

  localparam logic [7:0] CR_CHAR    = 8'h0D;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] MINUS_CHAR = 8'h2D;

  // bench sizing
  localparam int STREAM_BYTES = 1200;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;

  // one result word as the block presents it
  typedef struct packed {
    logic [2:0]  status;
    logic        key_down;
    logic [6:0]  key_number;
    logic [5:0]  voice_slot;
    logic [31:0] onset_time;
    logic [13:0] amplitude;
  } key_result_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte  = 8'h00;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [2:0]  out_status;
  logic        out_key_down;
  logic [6:0]  out_key_number;
  logic [5:0]  out_voice_slot;
  logic [31:0] out_onset_time;
  logic [13:0] out_amplitude;

  // stimulus and scoreboard storage
  logic [7:0]  pending_bytes[$];
  key_result_t expected_results[$];
  int          total_bytes  = 0;
  int          sent_count   = 0;
  int          error_count  = 0;
  int          result_count = 0;
  int          quiet_cycles = 0;
  logic        byte_taken   = 1'b0;

  // parser state mirrored in the bench
  logic        frame_open;
  int          frame_len;
  logic [7:0]  frame_kind;
  logic [1:0]  key_flags;
  logic [31:0] key_value;
  logic [1:0]  time_flags;
  logic [31:0] time_value;
  logic [7:0]  last_byte;

  always #10 clk = ~clk;

  key_event_message_parser_core #(
    .MAX_LEN    (MSG_MAX_LEN),
    .NUM_VOICES (VOICE_COUNT)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_key_down    (out_key_down),
    .out_key_number  (out_key_number),
    .out_voice_slot  (out_voice_slot),
    .out_onset_time  (out_onset_time),
    .out_amplitude   (out_amplitude)
  );

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // one decimal digit step: skip leading white space, take digits, saturate
  task automatic digit_step(inout logic [1:0] flags, inout logic [31:0] acc,
                            input logic [7:0] b);
    logic [35:0] wide;
    if (flags == PF_SKIP || flags == PF_DIGITS) begin
      if (b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
        wide  = 36'(acc) * 36'd10 + 36'(b) - 36'(DIGIT_ZERO);
        acc   = (wide > 36'(TIME_MAX)) ? TIME_MAX : wide[31:0];
        flags = PF_DIGITS;
      end else if (flags == PF_DIGITS) begin
        flags = PF_STOPPED;
      end else if (!(b == SPACE_CHAR || (b >= WS_LO && b <= WS_HI))) begin
        flags = PF_FAILED;
      end
    end
  endtask

  // gain in q0.16: round(clamp(1.03e-4*(10000-t), 0.1, 1) / 6), ties up
  function automatic logic [13:0] gain_for(input logic [31:0] t);
    longint unsigned span;
    if (t <= 32'd291)
      span = 64'd1000000;
    else if (t >= 32'd9030)
      span = 64'd100000;
    else
      span = 64'd103 * (64'd10000 - 64'(t));
    return 14'((span * 64'd65536 + 64'd3000000) / 64'd6000000);
  endfunction

  // advance the mirrored parser by one accepted byte, queue a result on LF
  task automatic track_byte(input logic [7:0] b);
    int          pos;
    key_result_t res;
    pos = frame_len;
    if (!frame_open) begin
      // hunting for the start byte, everything else is dropped
      if (b == START_BYTE) begin
        frame_open = 1'b1;
        frame_len  = 0;
        frame_kind = 8'h00;
        key_flags  = PF_SKIP;
        key_value  = '0;
        time_flags = PF_SKIP;
        time_value = '0;
        last_byte  = 8'h00;
      end
    end else if (b != END_BYTE) begin
      if (pos < MSG_MAX_LEN) begin
        if (pos == 0) frame_kind = b;
        if (pos == 2 || pos == 3) digit_step(key_flags, key_value, b);
        // time runs one byte behind so CR and LF never reach it
        if (pos >= 5) digit_step(time_flags, time_value, last_byte);
        frame_len = pos + 1;
      end
      last_byte = b;
    end else begin
      frame_open = 1'b0;
      res = '0;
      if (pos + 1 >= MSG_MAX_LEN) begin
        res.status = ST_TOO_LONG;
      end else begin
        if (pos == 0) frame_kind = b;
        if (pos == 2 || pos == 3) digit_step(key_flags, key_value, b);
        // error precedence: type, then key, then time
        if (frame_kind != KIND_DOWN && frame_kind != KIND_UP)
          res.status = ST_BAD_TYPE;
        else if (key_flags != PF_DIGITS && key_flags != PF_STOPPED)
          res.status = ST_BAD_KEY;
        else if (frame_kind == KIND_DOWN && time_flags != PF_DIGITS &&
                 time_flags != PF_STOPPED)
          res.status = ST_BAD_TIME;
        else
          res.status = ST_OK;
      end
      if (res.status == ST_OK) begin
        res.key_down   = (frame_kind == KIND_DOWN);
        res.key_number = key_value[6:0];
        res.voice_slot = 6'(key_value % VOICE_COUNT);
        if (res.key_down) begin
          res.onset_time = time_value;
          res.amplitude  = gain_for(time_value);
        end
      end
      expected_results.push_back(res);
      last_byte = b;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      pending_bytes.push_back(s[i]);
  endtask

  // text followed by CR LF
  task automatic push_line(input string s);
    push_text(s);
    pending_bytes.push_back(CR_CHAR);
    pending_bytes.push_back(END_BYTE);
  endtask

  function automatic logic [7:0] any_but_lf();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == END_BYTE);
    return b;
  endfunction

  function automatic logic [7:0] rand_digit();
    return DIGIT_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // white space the number parser skips, LF left out since it ends a frame
  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 4))
      0:       return SPACE_CHAR;
      1:       return 8'h09;
      2:       return 8'h0B;
      3:       return 8'h0C;
      default: return CR_CHAR;
    endcase
  endfunction

  function automatic logic [7:0] rand_sign();
    return $urandom_range(0, 1) ? PLUS_CHAR : MINUS_CHAR;
  endfunction

  // two key bytes: mostly good, some one-digit, blank-led or broken fields
  task automatic push_key_field();
    case ($urandom_range(0, 9))
      6: begin
        pending_bytes.push_back(rand_blank());
        pending_bytes.push_back(rand_digit());
      end
      7: begin
        pending_bytes.push_back(rand_digit());
        pending_bytes.push_back(any_but_lf());
      end
      8: begin
        pending_bytes.push_back(rand_blank());
        pending_bytes.push_back(rand_blank());
      end
      9: begin
        pending_bytes.push_back(rand_sign());
        pending_bytes.push_back(rand_digit());
      end
      default: begin
        pending_bytes.push_back(rand_digit());
        pending_bytes.push_back(rand_digit());
      end
    endcase
  endtask

  // time field, aimed at both clamp knees, the slope and saturation
  task automatic push_time_field();
    int pad;
    pad = $urandom_range(0, 2);
    for (int i = 0; i < pad; i++)
      pending_bytes.push_back(rand_blank());
    case ($urandom_range(0, 9))
      0, 1:    push_text($sformatf("%0d", $urandom_range(0, 400)));
      2, 3, 4: push_text($sformatf("%0d", $urandom_range(280, 9100)));
      5:       push_text($sformatf("%0d", $urandom_range(9000, 99999)));
      6: begin
        case ($urandom_range(0, 5))
          0: push_text("290");
          1: push_text("291");
          2: push_text("292");
          3: push_text("9029");
          4: push_text("9030");
          default: push_text("4294967295");
        endcase
      end
      7: begin
        pad = $urandom_range(10, 12);
        for (int i = 0; i < pad; i++)
          pending_bytes.push_back(rand_digit());
      end
      8: begin
        // signs are not numbers
        pending_bytes.push_back(rand_sign());
        push_text($sformatf("%0d", $urandom_range(0, 999)));
      end
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0)
      pending_bytes.push_back(any_but_lf());
  endtask

  // one frame with random content, mostly well formed
  task automatic push_random_frame();
    int mode;
    int len;
    mode = $urandom_range(0, 99);
    // a little line noise ahead of the start byte
    if ($urandom_range(0, 4) == 0) begin
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++)
        pending_bytes.push_back(8'($urandom_range(0, 255)) & 8'hFF);
    end
    pending_bytes.push_back(START_BYTE);
    if (mode < 70) begin
      // well formed layout with random fields
      pending_bytes.push_back($urandom_range(0, 1) ? KIND_DOWN : KIND_UP);
      case ($urandom_range(0, 7))
        0:       pending_bytes.push_back(START_BYTE);
        1:       pending_bytes.push_back(8'h00);
        2:       pending_bytes.push_back(any_but_lf());
        default: pending_bytes.push_back(SPACE_CHAR);
      endcase
      push_key_field();
      // type byte sits ahead of the separator and the two key bytes
      if (pending_bytes[pending_bytes.size() - 4] == KIND_DOWN || $urandom_range(0, 1))
        push_time_field();
      push_line("");
    end else if (mode < 82) begin
      // arbitrary junk up to the terminator, 0 to 30 bytes long
      len = $urandom_range(0, 30);
      for (int i = 0; i < len; i++)
        pending_bytes.push_back(any_but_lf());
      pending_bytes.push_back(END_BYTE);
    end else if (mode < 92) begin
      // long down frames around the length limit
      len = $urandom_range(MSG_MAX_LEN - 3, MSG_MAX_LEN + 6);
      pending_bytes.push_back(KIND_DOWN);
      pending_bytes.push_back(SPACE_CHAR);
      pending_bytes.push_back(rand_digit());
      pending_bytes.push_back(rand_digit());
      for (int i = 0; i < len - 6; i++)
        pending_bytes.push_back(rand_digit());
      push_line("");
    end else begin
      // terminator inside the type or key bytes
      len = $urandom_range(0, 3);
      for (int i = 0; i < len; i++)
        pending_bytes.push_back((i == 0) ? ($urandom_range(0, 1) ? KIND_DOWN : KIND_UP)
                                         : rand_digit());
      pending_bytes.push_back(END_BYTE);
    end
  endtask

  // ---------------------------------------------------------------------------
  // idling: sender light and receiver heavy, then swapped, then none
  // ---------------------------------------------------------------------------
  function automatic bit take_break(input bit sender_side);
    int pct;
    if (sent_count < total_bytes / 3)
      pct = sender_side ? 10 : 79;
    else if (sent_count < (2 * total_bytes) / 3)
      pct = sender_side ? 79 : 10;
    else
      pct = 0;
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                             result_count, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // driver: new byte word at the falling edge once the last one was taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    if (rst_n) begin
      if (!in_valid || byte_taken) begin
        if (pending_bytes.size() != 0 && !take_break(1'b1)) begin
          in_rx_byte <= pending_bytes.pop_front();
          in_valid   <= 1'b1;
          sent_count++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !take_break(1'b0);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on accepted bytes, compare accepted result words
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    key_result_t want;
    if (rst_n) begin
      byte_taken <= in_valid && in_ready;
      if (in_valid && in_ready)
        track_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("result word with none pending, status %0d", out_status));
        end else begin
          want = expected_results.pop_front();
          check_field("status",      32'(out_status),      32'(want.status));
          check_field("key_down",    32'(out_key_down),    32'(want.key_down));
          check_field("key_number",  32'(out_key_number),  32'(want.key_number));
          check_field("voice_slot",  32'(out_voice_slot),  32'(want.voice_slot));
          check_field("onset_time",  out_onset_time,       want.onset_time);
          check_field("amplitude",   32'(out_amplitude),   32'(want.amplitude));
        end
        result_count++;
      end
      // watchdog on cycles with no handshake on either side
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("stalled for %0d cycles, %0d result words still pending",
                 quiet_cycles, expected_results.size());
        $display("FAIL key_event_message_parser_core");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    frame_open = 1'b0;
    frame_len  = 0;
    frame_kind = 8'h00;
    key_flags  = PF_SKIP;
    key_value  = '0;
    time_flags = PF_SKIP;
    time_value = '0;
    last_byte  = 8'h00;

    // directed: byte extremes outside a frame, key up, saturated key down
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    push_line("SU 07");
    push_line("SD 42 99999999999");

    while (pending_bytes.size() < STREAM_BYTES)
      push_random_frame();
    // close any frame left open by the last bytes
    pending_bytes.push_back(END_BYTE);
    total_bytes = pending_bytes.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    // room for a stray word after the last expected one
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0)
      $display("PASS key_event_message_parser_core");
    else
      $display("FAIL key_event_message_parser_core");
    $finish;
  end

endmodule
